// File: hdl/ouart_pkg.sv
// ----------------------------------------------------------------------------
// ouart_pkg
// Shared types and constants for the oversampled UART with receive FIFO.
// ----------------------------------------------------------------------------
package ouart_pkg;

    // Request commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SEND  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_MODE_8BIT     = 2'd0,
        REG_RX_DATA_BITS  = 2'd1,
        REG_TX_FRAME_BITS = 2'd2,
        REG_RX_ENABLE     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic       mode_8bit;
        logic [3:0] rx_data_bits;
        logic [4:0] tx_frame_bits;
        logic       rx_enable;
    } cfg_t;

    localparam int CFG_ADDR_W = 4;
    localparam int FIFO_DEPTH_DEFAULT = 16;

    localparam logic       MODE_8BIT_RST     = 1'b0;
    localparam logic [3:0] RX_DATA_BITS_RST  = 4'd5;
    localparam logic [4:0] TX_FRAME_BITS_RST = 5'd8;
    localparam logic       RX_ENABLE_RST     = 1'b1;

    // Stop-bit patterns ORed over the shifted character
    localparam logic [15:0] TTY_STOP_PATTERN  = 16'h00C0;
    localparam logic [15:0] BYTE_STOP_PATTERN = 16'h0200;

    // Ticks per bit, and ticks from start edge to first data sample
    localparam logic [1:0] TX_BIT_TICKS   = 2'd3;
    localparam logic [2:0] RX_BIT_TICKS   = 3'd3;
    localparam logic [2:0] RX_FIRST_TICKS = 3'd4;

endpackage

// File: hdl/ouart_if.sv
// ----------------------------------------------------------------------------
// ouart_if
// Request and result channels of the oversampled UART.
// ----------------------------------------------------------------------------
interface ouart_req_if;
    logic              valid;
    logic              ready;
    ouart_pkg::cmd_t   cmd;
    logic [7:0]        tx_char;
    logic              rx_pin;

    modport source (output valid, output cmd, output tx_char, output rx_pin, input ready);
    modport sink   (input valid, input cmd, input tx_char, input rx_pin, output ready);
endinterface

interface ouart_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic [7:0] rx_byte;
    logic       rx_byte_valid;
    logic       rx_available;
    logic       tx_busy;
    logic       put_accepted;
    logic       line_break;

    modport source (output valid, output tx_line, output rx_byte, output rx_byte_valid,
                    output rx_available, output tx_busy, output put_accepted,
                    output line_break, input ready);
    modport sink   (input valid, input tx_line, input rx_byte, input rx_byte_valid,
                    input rx_available, input tx_busy, input put_accepted,
                    input line_break, output ready);
endinterface

// File: hdl/ouart_ram.sv
// ----------------------------------------------------------------------------
// ouart_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ouart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ouart_cfg.sv
// ----------------------------------------------------------------------------
// ouart_cfg
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module ouart_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ouart_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output ouart_pkg::cfg_t                 cfg
);
    import ouart_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MODE_8BIT:     cfg_next.mode_8bit     = pwdata[0];
                REG_RX_DATA_BITS:  cfg_next.rx_data_bits  = pwdata[3:0];
                REG_TX_FRAME_BITS: cfg_next.tx_frame_bits = pwdata[4:0];
                REG_RX_ENABLE:     cfg_next.rx_enable     = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_8bit     <= MODE_8BIT_RST;
            cfg_reg.rx_data_bits  <= RX_DATA_BITS_RST;
            cfg_reg.tx_frame_bits <= TX_FRAME_BITS_RST;
            cfg_reg.rx_enable     <= RX_ENABLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_MODE_8BIT:     prdata = {31'd0, cfg_reg.mode_8bit};
            REG_RX_DATA_BITS:  prdata = {28'd0, cfg_reg.rx_data_bits};
            REG_TX_FRAME_BITS: prdata = {27'd0, cfg_reg.tx_frame_bits};
            REG_RX_ENABLE:     prdata = {31'd0, cfg_reg.rx_enable};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/oversampled_uart_with_rx_fifo.sv
// ----------------------------------------------------------------------------
// oversampled_uart_with_rx_fifo
// UART driven by a tick at three times baud, with a receive ring FIFO.
// ----------------------------------------------------------------------------
//  channel  dir    handshake      payload
//  req      sink   valid/ready    cmd, tx_char, rx_pin
//  rsp      source valid/ready    tx_line, rx_byte, rx_byte_valid, rx_available,
//                                 tx_busy, put_accepted, line_break
//  apb      slave  psel/penable   paddr, pwdata, prdata (pready tied high)
//
// One request per cycle; each result appears in the cycle after its request.
// The result register and the FIFO RAM's registered read port set that latency.
// A stalled result blocks new requests; the popped byte is held in the RAM
// read register until the next pop. Reset clears all control state at once;
// the FIFO RAM is not cleared.
// ----------------------------------------------------------------------------
module oversampled_uart_with_rx_fifo #(
    parameter int FIFO_DEPTH = ouart_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ouart_req_if.sink                        req,
    ouart_rsp_if.source                      rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ouart_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import ouart_pkg::*;

    localparam int IW = $clog2(FIFO_DEPTH);
    localparam logic [IW-1:0] LAST_INDEX = IW'(FIFO_DEPTH - 1);

    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
        if (i == LAST_INDEX)
            return '0;
        else
            return i + 1'b1;
    endfunction

    cfg_t cfg;

    ouart_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Transmit and receive state
    logic [15:0]   tx_shift_reg, tx_shift_next;
    logic [1:0]    tx_tick_reg, tx_tick_next;
    logic [4:0]    tx_bits_reg, tx_bits_next;
    logic          tx_active_reg, tx_active_next;
    logic          tx_level_reg, tx_level_next;
    logic          rx_busy_reg, rx_busy_next;
    logic          rx_wait_reg, rx_wait_next;
    logic [2:0]    rx_tick_reg, rx_tick_next;
    logic [3:0]    rx_bits_reg, rx_bits_next;
    logic [7:0]    rx_mask_reg, rx_mask_next;
    logic [7:0]    rx_shift_reg, rx_shift_next;
    logic          break_reg, break_next;
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;

    // Result register
    logic          rsp_valid_reg;
    logic          rsp_tx_line_reg, rsp_pop_reg, rsp_avail_reg;
    logic          rsp_busy_reg, rsp_put_reg, rsp_ferr_reg;

    logic          accept;
    logic          line;
    logic [1:0]    tx_tick_eff;
    logic          push;
    logic          pop;
    logic          put_ok;
    logic [7:0]    pop_data;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign line      = !req.rx_pin;

    // Compute the next state for an accepted request
    always_comb
    begin
        tx_shift_next  = tx_shift_reg;
        tx_tick_next   = tx_tick_reg;
        tx_bits_next   = tx_bits_reg;
        tx_active_next = tx_active_reg;
        tx_level_next  = tx_level_reg;
        rx_busy_next   = rx_busy_reg;
        rx_wait_next   = rx_wait_reg;
        rx_tick_next   = rx_tick_reg;
        rx_bits_next   = rx_bits_reg;
        rx_mask_next   = rx_mask_reg;
        rx_shift_next  = rx_shift_reg;
        break_next     = break_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        push           = 1'b0;
        pop            = 1'b0;
        put_ok         = 1'b0;

        // Shorten the last teletype stop bit
        tx_tick_eff = tx_tick_reg;
        if (!cfg.mode_8bit && tx_bits_reg == 5'd1 && tx_tick_reg == 2'd2)
            tx_tick_eff = 2'd1;

        if (accept)
        begin
            case (req.cmd)
                CMD_TICK:
                begin
                    // Advance the transmitter
                    if (tx_active_reg)
                    begin
                        if (tx_tick_eff <= 2'd1)
                        begin
                            tx_level_next = tx_shift_reg[0];
                            tx_shift_next = {1'b0, tx_shift_reg[15:1]};
                            tx_tick_next  = TX_BIT_TICKS;
                            if (tx_bits_reg <= 5'd1)
                            begin
                                tx_bits_next   = 5'd0;
                                tx_active_next = 1'b0;
                            end
                            else
                            begin
                                tx_bits_next = tx_bits_reg - 5'd1;
                            end
                        end
                        else
                        begin
                            tx_tick_next = tx_tick_eff - 2'd1;
                        end
                    end

                    // Advance the receiver
                    if (cfg.rx_enable)
                    begin
                        if (rx_wait_reg)
                        begin
                            if (rx_tick_reg <= 3'd1)
                            begin
                                rx_tick_next = 3'd0;
                                rx_wait_next = 1'b0;
                                rx_busy_next = 1'b0;
                                push         = 1'b1;
                                wr_idx_next  = wrap_next(wr_idx_reg);
                            end
                            else
                            begin
                                rx_tick_next = rx_tick_reg - 3'd1;
                                if (rx_shift_reg == 8'd0 && !line)
                                    break_next = 1'b1;
                            end
                        end
                        else if (!rx_busy_reg)
                        begin
                            if (!line)
                            begin
                                rx_busy_next  = 1'b1;
                                rx_shift_next = 8'd0;
                                rx_tick_next  = RX_FIRST_TICKS;
                                rx_bits_next  = cfg.rx_data_bits;
                                rx_mask_next  = 8'd1;
                            end
                        end
                        else if (rx_tick_reg <= 3'd1)
                        begin
                            rx_tick_next = RX_BIT_TICKS;
                            if (line)
                                rx_shift_next = rx_shift_reg | rx_mask_reg;
                            rx_mask_next = {rx_mask_reg[6:0], 1'b0};
                            if (rx_bits_reg <= 4'd1)
                            begin
                                rx_bits_next = 4'd0;
                                rx_wait_next = 1'b1;
                            end
                            else
                            begin
                                rx_bits_next = rx_bits_reg - 4'd1;
                            end
                        end
                        else
                        begin
                            rx_tick_next = rx_tick_reg - 3'd1;
                        end
                    end
                end

                CMD_SEND:
                begin
                    // Load a frame unless one is still going out
                    if (!tx_active_reg)
                    begin
                        tx_tick_next   = TX_BIT_TICKS;
                        tx_bits_next   = cfg.tx_frame_bits;
                        tx_shift_next  = {7'd0, req.tx_char, 1'b0} |
                                         (cfg.mode_8bit ? BYTE_STOP_PATTERN : TTY_STOP_PATTERN);
                        tx_active_next = 1'b1;
                        put_ok         = 1'b1;
                    end
                end

                CMD_POP:
                begin
                    if (rd_idx_reg != wr_idx_reg)
                    begin
                        pop         = 1'b1;
                        rd_idx_next = wrap_next(rd_idx_reg);
                    end
                end

                CMD_FLUSH:
                begin
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                end

                default:
                begin
                    wr_idx_next = wr_idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg  <= '0;
            tx_tick_reg   <= '0;
            tx_bits_reg   <= '0;
            tx_active_reg <= 1'b0;
            tx_level_reg  <= 1'b1;
            rx_busy_reg   <= 1'b0;
            rx_wait_reg   <= 1'b0;
            rx_tick_reg   <= '0;
            rx_bits_reg   <= '0;
            rx_mask_reg   <= '0;
            rx_shift_reg  <= '0;
            break_reg     <= 1'b0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            tx_shift_reg  <= tx_shift_next;
            tx_tick_reg   <= tx_tick_next;
            tx_bits_reg   <= tx_bits_next;
            tx_active_reg <= tx_active_next;
            tx_level_reg  <= tx_level_next;
            rx_busy_reg   <= rx_busy_next;
            rx_wait_reg   <= rx_wait_next;
            rx_tick_reg   <= rx_tick_next;
            rx_bits_reg   <= rx_bits_next;
            rx_mask_reg   <= rx_mask_next;
            rx_shift_reg  <= rx_shift_next;
            break_reg     <= break_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    // Receive FIFO storage
    ouart_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_idx_reg),
        .wdata (rx_shift_reg),
        .re    (pop),
        .raddr (rd_idx_reg),
        .rdata (pop_data)
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_tx_line_reg <= tx_level_next;
            rsp_pop_reg     <= pop;
            rsp_avail_reg   <= (rd_idx_next != wr_idx_next);
            rsp_busy_reg    <= tx_active_next;
            rsp_put_reg     <= put_ok;
            rsp_ferr_reg    <= break_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.tx_line       = rsp_tx_line_reg;
    assign rsp.rx_byte       = rsp_pop_reg ? pop_data : 8'd0;
    assign rsp.rx_byte_valid = rsp_pop_reg;
    assign rsp.rx_available  = rsp_avail_reg;
    assign rsp.tx_busy       = rsp_busy_reg;
    assign rsp.put_accepted  = rsp_put_reg;
    assign rsp.line_break    = rsp_ferr_reg;

endmodule
